// ----- rtl/psr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the periodic sensor report block: payload structs, register map,
// temperature table and widths shared by all modules. Depends on nothing.
package psr_pkg;

    // Widths of the samples and of the report bytes.
    localparam int SAMPLE_W = 10;
    localparam int BYTE_W   = 8;

    // Default number of temperature table entries used by the interpolation.
    localparam int TABLE_ENTRIES_DEF = 103;

    // Configuration port geometry: eight 32-bit registers at word addresses.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REPORT_SECONDS     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REPORT_MINUTES     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HUMIDITY_MIN_COUNT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HUMIDITY_MAX_COUNT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HUMIDITY_SLOPE     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_FIRST_COUNT   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_STEP_COUNT    = 3'd7;

    // Byte kinds of a report, in the order they are sent.
    localparam logic [1:0] KIND_PACKET   = 2'd0;
    localparam logic [1:0] KIND_HUMIDITY = 2'd1;
    localparam logic [1:0] KIND_TEMP     = 2'd2;

    // Seconds per minute and the scale of the table (hundredths of a degree).
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int TEMP_SCALE         = 100;

    // Queue depths.
    localparam int JOBQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    // Temperature table in hundredths of a degree; entries beyond it read zero.
    localparam int ROM_SIZE  = 103;
    localparam int ROM_W     = 17;
    localparam int ROM_IDX_W = $clog2(ROM_SIZE);

    localparam int TEMP_ROM [ROM_SIZE] = '{
        -8699, -5905, -4991, -4396, -3945, -3576, -3261, -2984, -2737, -2511,
        -2303, -2110, -1929, -1758, -1595, -1441, -1292, -1150, -1012, -879,
        -750, -625, -503, -383, -266, -152, -40, 71, 180, 287,
        393, 497, 601, 703, 805, 905, 1006, 1105, 1204, 1303,
        1402, 1500, 1598, 1696, 1795, 1893, 1992, 2090, 2190, 2289,
        2389, 2490, 2591, 2693, 2796, 2900, 3005, 3111, 3219, 3327,
        3437, 3549, 3663, 3778, 3895, 4014, 4136, 4260, 4387, 4517,
        4650, 4786, 4926, 5070, 5218, 5371, 5529, 5692, 5862, 6038,
        6222, 6414, 6615, 6826, 7049, 7284, 7534, 7801, 8087, 8395,
        8730, 9096, 9500, 9952, 10462, 11048, 11736, 12567, 13609, 14994,
        17020, 20611, 33042
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] humidity_sample;
        logic [SAMPLE_W-1:0] temperature_sample;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] report_byte;
        logic [1:0]        byte_kind;
        logic              last_byte;
    } t_out_item;

    // One report to be built: packet number and the samples of its tick.
    typedef struct packed {
        logic [BYTE_W-1:0]   packet_number;
        logic [SAMPLE_W-1:0] humidity_sample;
        logic [SAMPLE_W-1:0] temperature_sample;
    } t_job;

    typedef struct packed {
        logic [7:0]          ticks_per_second;
        logic [5:0]          report_seconds;
        logic [7:0]          report_minutes;
        logic [SAMPLE_W-1:0] humidity_min_count;
        logic [SAMPLE_W-1:0] humidity_max_count;
        logic [15:0]         humidity_slope;
        logic [SAMPLE_W-1:0] temp_first_count;
        logic [SAMPLE_W-1:0] temp_step_count;
    } t_cfg;

    function automatic logic signed [ROM_W-1:0] temp_rom(input logic [SAMPLE_W-1:0] idx);
        logic signed [ROM_W-1:0] val;
        val = '0;
        if (idx < SAMPLE_W'(ROM_SIZE)) begin
            val = ROM_W'(TEMP_ROM[idx[ROM_IDX_W-1:0]]);
        end
        return val;
    endfunction

    function automatic logic [1:0] next_kind(input logic [1:0] kind);
        logic [1:0] nk;
        case (kind)
            KIND_PACKET:   nk = KIND_HUMIDITY;
            KIND_HUMIDITY: nk = KIND_TEMP;
            default:       nk = KIND_PACKET;
        endcase
        return nk;
    endfunction

endpackage

// ----- rtl/psr_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file with its APB-style access port.
// Depends on psr_pkg for the register map and the t_cfg struct.
module psr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output psr_pkg::t_cfg                   o_cfg
);
    import psr_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second   <= 8'd20;
            r_cfg.report_seconds     <= 6'd0;
            r_cfg.report_minutes     <= 8'd1;
            r_cfg.humidity_min_count <= SAMPLE_W'(0);
            r_cfg.humidity_max_count <= SAMPLE_W'(614);
            r_cfg.humidity_slope     <= 16'd10677;
            r_cfg.temp_first_count   <= SAMPLE_W'(0);
            r_cfg.temp_step_count    <= SAMPLE_W'(10);
        end else if (wr_en) begin
            case (reg_idx)
                REG_TICKS_PER_SECOND:   r_cfg.ticks_per_second   <= pwdata[7:0];
                REG_REPORT_SECONDS:     r_cfg.report_seconds     <= pwdata[5:0];
                REG_REPORT_MINUTES:     r_cfg.report_minutes     <= pwdata[7:0];
                REG_HUMIDITY_MIN_COUNT: r_cfg.humidity_min_count <= pwdata[SAMPLE_W-1:0];
                REG_HUMIDITY_MAX_COUNT: r_cfg.humidity_max_count <= pwdata[SAMPLE_W-1:0];
                REG_HUMIDITY_SLOPE:     r_cfg.humidity_slope     <= pwdata[15:0];
                REG_TEMP_FIRST_COUNT:   r_cfg.temp_first_count   <= pwdata[SAMPLE_W-1:0];
                REG_TEMP_STEP_COUNT:    r_cfg.temp_step_count    <= pwdata[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TICKS_PER_SECOND:   prdata = APB_DATA_W'(r_cfg.ticks_per_second);
            REG_REPORT_SECONDS:     prdata = APB_DATA_W'(r_cfg.report_seconds);
            REG_REPORT_MINUTES:     prdata = APB_DATA_W'(r_cfg.report_minutes);
            REG_HUMIDITY_MIN_COUNT: prdata = APB_DATA_W'(r_cfg.humidity_min_count);
            REG_HUMIDITY_MAX_COUNT: prdata = APB_DATA_W'(r_cfg.humidity_max_count);
            REG_HUMIDITY_SLOPE:     prdata = APB_DATA_W'(r_cfg.humidity_slope);
            REG_TEMP_FIRST_COUNT:   prdata = APB_DATA_W'(r_cfg.temp_first_count);
            REG_TEMP_STEP_COUNT:    prdata = APB_DATA_W'(r_cfg.temp_step_count);
            default:                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/psr_front.sv -----
`timescale 1ns / 1ps
// Front end: tick prescaler, seconds and minutes counts, packet numbering.
// Depends on psr_pkg; issues one job per report into the job queue.
module psr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psr_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  psr_pkg::t_in_item i_item,
    output logic              o_job_push,
    output psr_pkg::t_job     o_job
);
    import psr_pkg::*;

    logic [7:0]        r_tick;
    logic [5:0]        r_sec;
    logic [7:0]        r_min;
    logic [BYTE_W-1:0] r_pkt;

    logic [7:0] tick_inc;
    logic       sec_edge;
    logic [5:0] sec_inc;
    logic       sec_wrap;
    logic [5:0] sec_new;
    logic [7:0] min_new;
    logic       report;

    assign tick_inc = r_tick + 8'd1;
    assign sec_edge = (tick_inc == i_cfg.ticks_per_second);
    assign sec_inc  = r_sec + 6'd1;
    assign sec_wrap = (sec_inc == 6'(SECONDS_PER_MINUTE));
    assign sec_new  = sec_wrap ? 6'd0 : sec_inc;
    assign min_new  = sec_wrap ? (r_min + 8'd1) : r_min;
    assign report   = sec_edge && (sec_new == i_cfg.report_seconds)
                      && (min_new == i_cfg.report_minutes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_sec  <= '0;
            r_min  <= '0;
            r_pkt  <= '0;
        end else if (i_accept) begin
            if (!sec_edge) begin
                r_tick <= tick_inc;
            end else begin
                r_tick <= '0;
                if (report) begin
                    r_sec <= '0;
                    r_min <= '0;
                    r_pkt <= r_pkt + 8'd1;
                end else begin
                    r_sec <= sec_new;
                    r_min <= min_new;
                end
            end
        end
    end

    assign o_job_push               = i_accept && report;
    assign o_job.packet_number      = r_pkt + 8'd1;
    assign o_job.humidity_sample    = i_item.humidity_sample;
    assign o_job.temperature_sample = i_item.temperature_sample;

endmodule

// ----- rtl/psr_jobq.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Depends on psr_pkg for t_job and the queue depth.
module psr_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output psr_pkg::t_job o_job
);
    import psr_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);

    t_job             r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(JOBQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- rtl/psr_back.sv -----
`timescale 1ns / 1ps
// Back end: builds the three report bytes of a job with a bit-serial index
// divider and a bit-serial scaling divider. Depends on psr_pkg.
module psr_back #(
    parameter int TABLE_ENTRIES = psr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psr_pkg::t_cfg         i_cfg,
    input  logic                  i_job_valid,
    input  psr_pkg::t_job         i_job,
    output logic                  o_job_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output psr_pkg::t_out_item    o_result
);
    import psr_pkg::*;

    localparam logic [SAMPLE_W-1:0] LAST_IDX = SAMPLE_W'(TABLE_ENTRIES - 1);
    localparam int HUM_W  = SAMPLE_W + 16;
    localparam int SPAN_W = 2 * SAMPLE_W;
    localparam int PA_W   = ROM_W + SAMPLE_W + 1;
    localparam int PB_W   = ROM_W + SAMPLE_W + 2;
    localparam int NUM_W  = PB_W + 1;
    localparam int DIV_W  = SAMPLE_W + $clog2(TEMP_SCALE);
    localparam int Q_W    = 9;
    localparam int DSH_W  = DIV_W + Q_W - 1;
    localparam int CNT_W  = $clog2(SAMPLE_W);
    localparam int OQ_PTR_W = $clog2(OUTQ_DEPTH);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_KDIV  = 9'b000001000,
        ST_ROM   = 9'b000010000,
        ST_PROD  = 9'b000100000,
        ST_SUM   = 9'b001000000,
        ST_QDIV  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } t_back_state;

    t_back_state r_state;

    logic [BYTE_W-1:0]       r_pkt;
    logic [SAMPLE_W-1:0]     r_hs;
    logic [SAMPLE_W-1:0]     r_ts;
    logic [BYTE_W-1:0]       r_hum;
    logic [BYTE_W-1:0]       r_temp;
    logic [SAMPLE_W-1:0]     r_p;
    logic [SPAN_W-1:0]       r_span;
    logic                    r_below;
    logic [SAMPLE_W-1:0]     r_diff;
    logic [SAMPLE_W:0]       r_rem;
    logic [SAMPLE_W-1:0]     r_dvd;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_top;
    logic signed [ROM_W-1:0] r_lo;
    logic signed [ROM_W:0]   r_delta;
    logic signed [PA_W-1:0]  r_pa;
    logic signed [PB_W-1:0]  r_pb;
    logic [DIV_W-1:0]        r_div;
    logic                    r_neg;
    logic [NUM_W-1:0]        r_mag;
    logic [DSH_W-1:0]        r_dsh;
    logic [Q_W-1:0]          r_q;
    logic [1:0]              r_kind;

    t_out_item             r_oq [OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_owp;
    logic [OQ_PTR_W-1:0]   r_orp;
    logic [OQ_PTR_W:0]     r_ocnt;

    logic [SAMPLE_W-1:0]     p_eff;
    logic [HUM_W-1:0]        hum_prod;
    logic                    hum_ok;
    logic [SPAN_W-1:0]       span;
    logic [SAMPLE_W:0]       k_trial;
    logic                    k_ge;
    logic                    k_top;
    logic [SAMPLE_W-1:0]     lo_idx;
    logic signed [ROM_W-1:0] rom_lo;
    logic signed [ROM_W-1:0] rom_hi;
    logic signed [ROM_W:0]   delta;
    logic signed [PA_W-1:0]  pa;
    logic signed [PB_W-1:0]  pb;
    logic signed [NUM_W-1:0] num;
    logic                    q_ge;
    logic [Q_W-1:0]          q_fin;
    logic [BYTE_W-1:0]       q_byte;
    logic                    oq_full;
    logic                    oq_push;
    logic                    oq_pop;
    t_out_item               emit_item;

    // A step of zero behaves as a step of one.
    assign p_eff    = (i_cfg.temp_step_count == '0) ? SAMPLE_W'(1) : i_cfg.temp_step_count;
    assign hum_prod = HUM_W'(r_hs) * HUM_W'(i_cfg.humidity_slope);
    assign hum_ok   = (r_hs > i_cfg.humidity_min_count) && (r_hs < i_cfg.humidity_max_count);
    assign span     = SPAN_W'(p_eff) * SPAN_W'(LAST_IDX);

    // Restoring division of the offset by the step, one quotient bit a cycle.
    assign k_trial = {r_rem[SAMPLE_W-1:0], r_dvd[SAMPLE_W-1]};
    assign k_ge    = (k_trial >= {1'b0, r_p});

    // Past the last interval the last entry is used on its own.
    assign k_top  = (r_dvd >= LAST_IDX);
    assign lo_idx = k_top ? LAST_IDX : r_dvd;
    assign rom_lo = temp_rom(lo_idx);
    assign rom_hi = temp_rom(r_dvd + SAMPLE_W'(1));
    assign delta  = (ROM_W+1)'(rom_hi) - (ROM_W+1)'(rom_lo);

    assign pa  = r_lo * $signed({1'b0, r_p});
    assign pb  = r_delta * $signed({1'b0, r_rem[SAMPLE_W-1:0]});
    assign num = NUM_W'(r_pa) + NUM_W'(r_pb);

    // The scaled quotient stays below 512 in magnitude, so nine steps suffice.
    assign q_ge   = (r_mag >= NUM_W'(r_dsh));
    assign q_fin  = {r_q[Q_W-2:0], q_ge};
    assign q_byte = r_neg ? (BYTE_W'(~q_fin) + BYTE_W'(1)) : BYTE_W'(q_fin);

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        emit_item.byte_kind = r_kind;
        emit_item.last_byte = (r_kind == KIND_TEMP);
        case (r_kind)
            KIND_PACKET:   emit_item.report_byte = r_pkt;
            KIND_HUMIDITY: emit_item.report_byte = r_hum;
            default:       emit_item.report_byte = r_temp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_below || (SPAN_W'(r_diff) > r_span)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_KDIV;
                    end
                end
                ST_KDIV: begin
                    if (r_cnt == CNT_W'(SAMPLE_W - 1)) begin
                        r_state <= ST_ROM;
                    end
                end
                ST_ROM: begin
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_state <= ST_QDIV;
                end
                ST_QDIV: begin
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!oq_full && (r_kind == KIND_TEMP)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pkt  <= i_job.packet_number;
                r_hs   <= i_job.humidity_sample;
                r_ts   <= i_job.temperature_sample;
                r_kind <= KIND_PACKET;
            end
            ST_PREP: begin
                r_hum   <= hum_ok ? hum_prod[16 +: BYTE_W] : {BYTE_W{1'b1}};
                r_p     <= p_eff;
                r_span  <= span;
                r_below <= (r_ts < i_cfg.temp_first_count);
                r_diff  <= r_ts - i_cfg.temp_first_count;
            end
            ST_CHECK: begin
                r_temp <= {BYTE_W{1'b1}};
                r_rem  <= '0;
                r_dvd  <= r_diff;
                r_cnt  <= '0;
            end
            ST_KDIV: begin
                r_rem <= k_ge ? (k_trial - {1'b0, r_p}) : k_trial;
                r_dvd <= {r_dvd[SAMPLE_W-2:0], k_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_ROM: begin
                r_top   <= k_top;
                r_lo    <= rom_lo;
                r_delta <= delta;
            end
            ST_PROD: begin
                if (r_top) begin
                    r_pa  <= PA_W'(r_lo);
                    r_pb  <= '0;
                    r_div <= DIV_W'(TEMP_SCALE);
                end else begin
                    r_pa  <= pa;
                    r_pb  <= pb;
                    r_div <= DIV_W'(r_p) * DIV_W'(TEMP_SCALE);
                end
            end
            ST_SUM: begin
                r_neg <= num[NUM_W-1];
                r_mag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                r_dsh <= {r_div, {(Q_W-1){1'b0}}};
                r_q   <= '0;
                r_cnt <= '0;
            end
            ST_QDIV: begin
                if (q_ge) begin
                    r_mag <= r_mag - NUM_W'(r_dsh);
                end
                r_q   <= q_fin;
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_temp <= q_byte;
                end
            end
            ST_EMIT: begin
                if (!oq_full) begin
                    r_kind <= next_kind(r_kind);
                end
            end
            default: begin
            end
        endcase
    end

    // Result queue.
    assign oq_full  = (r_ocnt == (OQ_PTR_W+1)'(OUTQ_DEPTH));
    assign oq_push  = (r_state == ST_EMIT) && !oq_full;
    assign o_empty  = (r_ocnt == '0);
    assign oq_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (oq_push) begin
                r_owp <= r_owp + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_orp <= r_orp + OQ_PTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                r_ocnt <= r_ocnt + (OQ_PTR_W+1)'(1);
            end else if (oq_pop && !oq_push) begin
                r_ocnt <= r_ocnt - (OQ_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_owp] <= emit_item;
        end
    end

endmodule

// ----- rtl/periodic_sensor_report.sv -----
`timescale 1ns / 1ps
// Top level of the periodic sensor report block.
// Depends on psr_pkg, psr_cfg, psr_front, psr_jobq and psr_back.
//
// Every accepted input item is one timer tick that carries the latest humidity
// and temperature samples. The front end counts ticks into seconds and seconds
// into minutes; when the count reaches the programmed interval it clears both
// counts, bumps the packet number and hands a job to the back end through a
// two-entry job queue. The back end turns each job into three result items:
// the packet number, the humidity byte and the temperature byte (the last one
// flagged with last_byte). Ticks are taken one per clock as long as the job
// queue has room, so full only rises while two reports wait in the job queue
// behind the one being built. In the back end a report goes through set-up,
// then, for a temperature within the table, the bit-serial table index
// divider, the table lookup, the multiplications and the bit-serial divider
// that scales the interpolated value to degrees, and last the three pushes
// into the four-entry result queue, which wait while that queue is full.
// Configuration registers sit on an APB-style port at byte addresses
// 0, 4, ... 28 and must only be written while no report is being built.
module periodic_sensor_report #(
    parameter int TABLE_ENTRIES = psr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Tick input.
    input  logic                           push,
    output logic                           full,
    input  psr_pkg::t_in_item              i_item,
    // Report bytes.
    output logic                           empty,
    input  logic                           pop,
    output psr_pkg::t_out_item             o_result,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [psr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [psr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import psr_pkg::*;

    t_cfg cfg;
    t_job front_job;
    t_job back_job;
    logic accept;
    logic job_push;
    logic job_valid;
    logic job_pop;

    // A tick is taken whenever the job queue can absorb a possible report.
    assign accept = push && !full;

    psr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    psr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (back_job)
    );

    psr_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (back_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ----- rtl/psr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for periodic_sensor_report and the bind that attaches it.
// Depends on psr_pkg for the result struct and byte kinds.
module psr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               pop,
    input logic               empty,
    input psr_pkg::t_out_item o_result
);
    import psr_pkg::*;

    logic [1:0]        r_exp_kind;
    logic              r_pkt_seen;
    logic [BYTE_W-1:0] r_last_pkt;
    logic              taken;

    assign taken = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_kind <= KIND_PACKET;
            r_pkt_seen <= 1'b0;
        end else if (taken) begin
            r_exp_kind <= next_kind(o_result.byte_kind);
            if (o_result.byte_kind == KIND_PACKET) begin
                r_pkt_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (taken && (o_result.byte_kind == KIND_PACKET)) begin
            r_last_pkt <= o_result.report_byte;
        end
    end

    // Reports leave as packet number, humidity, temperature, in that order.
    a_kind_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        taken |-> (o_result.byte_kind == r_exp_kind))
        else $error("report byte out of order");

    // Each report carries the packet number after the previous one.
    a_pkt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (taken && (o_result.byte_kind == KIND_PACKET) && r_pkt_seen)
        |-> (o_result.report_byte == (r_last_pkt + 8'd1)))
        else $error("packet number did not advance by one");

    // Nothing is waiting right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty)
        else $error("result waiting right after reset");

    // A waiting item that is not taken stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting item changed before it was taken");

endmodule

bind periodic_sensor_report psr_checker u_psr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
